[hdl/acmac_pkg.sv]
// acmac_pkg: shared types, constants and functions for the aes-128 cmac core
// no dependencies
`timescale 1ns / 1ps
package acmac_pkg;

  localparam int KeyWidth   = 64;
  localparam int BlockWidth = 128;
  localparam int LenWidth   = 5;
  localparam int RoundWidth = 4;
  localparam logic [RoundWidth-1:0] LastRound = 4'd10;
  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [7:0] DblConst = 8'h87;
  localparam logic [7:0] GfConst  = 8'h1B;

  // configuration register indexes
  localparam logic CfgKeyHigh = 1'b0;
  localparam logic CfgKeyLow  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DERIVE,
    ST_DERIVE_WAIT,
    ST_MAC,
    ST_MAC_WAIT,
    ST_OUT
  } state_t;

  // control from sequencer to round unit
  typedef struct packed {
    logic start;
    logic [BlockWidth-1:0] block;
  } rnd_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GfConst : 8'h00);
  endfunction

  // cmac doubling over 128 bits
  function automatic logic [BlockWidth-1:0] dbl(input logic [BlockWidth-1:0] v);
    return {v[BlockWidth-2:0], 1'b0} ^ {{(BlockWidth-8){1'b0}}, (v[BlockWidth-1] ? DblConst : 8'h00)};
  endfunction

endpackage

[hdl/aes128_cmac_single_block_core.sv]
// aes128_cmac_single_block_core: aes-128 cmac over one block, top level
// depends on acmac_pkg and acmac_round
//
// usage: write key_high (index 0) and key_low (index 1) through cfg_we,
// cfg_addr and cfg_data while idle. each input item on s_axis carries a
// message of up to 16 bytes and its length; one mac item per input leaves
// on m_axis.
// when subkeys are cached, the mac passes through a load step, ten rounds
// of the shared round unit and the output register. a new item is
// accepted only after m_axis has taken the mac and the sequencer has
// returned to idle. the first item after reset or after a key write first
// runs an extra aes pass to derive k1/k2. s_axis_tready is high only in
// idle, so one item is in work at a time.
// reset clears the sequencer and the subkey valid flag; the key registers
// clear to zero. a stalled m_axis holds the mac in its output register
// until taken; no new item is accepted meanwhile.
`timescale 1ns / 1ps
module aes128_cmac_single_block_core
  import acmac_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [KeyWidth-1:0] cfg_data,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // message_high [63:0], message_low [127:64], message_length [132:128], zero fill
  input  logic [135:0]        s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // mac_high [63:0], mac_low [127:64]
  output logic [127:0]        m_axis_tdata
);

  state_t state, state_next;
  logic [KeyWidth-1:0]   key_high, key_low;
  logic                  subkeys_ready;
  logic [BlockWidth-1:0] k1, k2;
  logic [BlockWidth-1:0] msg;
  logic [LenWidth-1:0]   len;
  logic [BlockWidth-1:0] padded;
  logic [BlockWidth-1:0] mac;
  rnd_ctl_t              ctl;
  logic                  done;
  logic [BlockWidth-1:0] result;

  acmac_round u_round (
    .clk(clk), .rst(rst), .ctl(ctl), .key({key_high, key_low}),
    .done(done), .result(result)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:        if (s_axis_tvalid) state_next = subkeys_ready ? ST_MAC : ST_DERIVE;
      ST_DERIVE:      state_next = ST_DERIVE_WAIT;
      ST_DERIVE_WAIT: if (done) state_next = ST_MAC;
      ST_MAC:         state_next = ST_MAC_WAIT;
      ST_MAC_WAIT:    if (done) state_next = ST_OUT;
      ST_OUT:         if (m_axis_tready) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  // padding and subkey mix
  always_comb begin
    padded = '0;
    for (int i = 0; i < 16; i++) begin
      if (len[4] || i < len) padded[127-8*i -: 8] = msg[127-8*i -: 8];
      else if (i == len) padded[127-8*i -: 8] = PadByte;
    end
    padded = padded ^ (len[4] ? k1 : k2);
  end

  // outputs
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = (state == ST_OUT);
    ctl.start     = (state == ST_DERIVE) || (state == ST_MAC);
    ctl.block     = (state == ST_MAC) ? padded : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      subkeys_ready <= 1'b0;
      key_high      <= '0;
      key_low       <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DERIVE_WAIT && done) subkeys_ready <= 1'b1;
      if (cfg_we) begin
        subkeys_ready <= 1'b0;
        if (cfg_addr == CfgKeyHigh) key_high <= cfg_data;
        else key_low <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid) begin
      msg <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
      len <= s_axis_tdata[132:128];
    end
    if (state == ST_DERIVE_WAIT && done) begin
      k1 <= dbl(result);
      k2 <= dbl(dbl(result));
    end
    if (state == ST_MAC_WAIT && done) mac <= result;
  end

  assign m_axis_tdata = {mac[63:0], mac[127:64]};

  a_one_start: assert property (@(posedge clk) disable iff (rst)
    ctl.start |=> !ctl.start) else $error("round unit restarted");
  a_out_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(done)) else $error("mac shown without round completion");
  a_no_mac_unkeyed: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC) |-> subkeys_ready) else $error("mac pass without subkeys");

endmodule

[hdl/acmac_round.sv]
// acmac_round: iterative aes-128 unit, one round and one key step per cycle
// depends on acmac_pkg
`timescale 1ns / 1ps
module acmac_round
  import acmac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  rnd_ctl_t              ctl,
  input  logic [BlockWidth-1:0] key,
  output logic                  done,
  output logic [BlockWidth-1:0] result
);

  logic [BlockWidth-1:0] st;
  logic [BlockWidth-1:0] rk;
  logic [RoundWidth-1:0] rnd;
  logic                  busy;
  logic [BlockWidth-1:0] st_next;
  logic [BlockWidth-1:0] rk_next;
  logic [7:0]            rcon;

  // round constant by round number
  always_comb begin
    case (rnd)
      4'd1:    rcon = 8'h01;
      4'd2:    rcon = 8'h02;
      4'd3:    rcon = 8'h04;
      4'd4:    rcon = 8'h08;
      4'd5:    rcon = 8'h10;
      4'd6:    rcon = 8'h20;
      4'd7:    rcon = 8'h40;
      4'd8:    rcon = 8'h80;
      4'd9:    rcon = 8'h1B;
      4'd10:   rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  end

  // key expansion step
  always_comb begin
    logic [31:0] t;
    logic [31:0] w [4];
    t = {sbox(rk[23:16]) ^ rcon, sbox(rk[15:8]), sbox(rk[7:0]), sbox(rk[31:24])};
    w[0] = rk[127:96] ^ t;
    w[1] = rk[95:64] ^ w[0];
    w[2] = rk[63:32] ^ w[1];
    w[3] = rk[31:0] ^ w[2];
    rk_next = {w[0], w[1], w[2], w[3]};
  end

  // subbytes, shiftrows, mixcolumns (skipped in the last round), addroundkey
  always_comb begin
    logic [7:0] b [16];
    logic [7:0] s [16];
    logic [7:0] a0, a1, a2, a3, al;
    for (int i = 0; i < 16; i++) b[i] = st[127-8*i -: 8];
    for (int i = 0; i < 16; i++) s[i] = sbox(b[(i + 4*(i%4)) % 16]);
    for (int c = 0; c < 4; c++) begin
      a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (rnd != LastRound) begin
        s[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        s[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        s[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        s[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) st_next[127-8*i -: 8] = s[i] ^ rk_next[127-8*i -: 8];
  end

  // round sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        rnd  <= 4'd1;
      end else if (busy) begin
        rnd <= rnd + 4'd1;
        if (rnd == LastRound) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      st <= ctl.block ^ key;
      rk <= key;
    end else if (busy) begin
      st <= st_next;
      rk <= rk_next;
    end
  end

  assign result = st;

endmodule
